FILE: src/searchable_message_queue_unit_assert.svh
// Assertion macros used by the checker file of the message queue.
`ifndef SEARCHABLE_MESSAGE_QUEUE_UNIT_ASSERT_SVH
`define SEARCHABLE_MESSAGE_QUEUE_UNIT_ASSERT_SVH

// Same-cycle property, sampled on clk_i and silenced while rst_ni is low.
`define SMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Property that holds in the cycle after its antecedent.
`define SMQ_ASSERT_NEXT(label, ante, cons, msg) \
  `SMQ_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: src/smq_pkg.sv
// Package with the widths, codes and types of the searchable message queue.
package smq_pkg;

  localparam int DEPTH        = 16;
  localparam int PAYLOAD_BITS = 64;
  localparam int ID_BITS      = 16;
  localparam int PRI_BITS     = 8;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);

  typedef logic [PRI_BITS-1:0]     pri_t;
  typedef logic [ID_BITS-1:0]      id_t;
  typedef logic [PAYLOAD_BITS-1:0] pay_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic {
    CMD_PUSH    = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_OLDEST   = 2'd0,
    MODE_EXACT    = 2'd1,
    MODE_AT_LEAST = 2'd2,
    MODE_NONE     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_PUSHED    = 3'd0,
    ST_FULL      = 3'd1,
    ST_EXTRACTED = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOMATCH   = 3'd4
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request and register the compare results
    logic commit;   // update the queue and load the result register
  } ctrl_t;

endpackage

FILE: src/smq_if.sv
// Request and result channel interfaces of the searchable message queue.
interface smq_in_if;
  logic                 valid;
  logic                 ready;
  smq_pkg::cmd_e        cmd;
  smq_pkg::pri_t        new_priority;
  smq_pkg::pay_t        new_payload;
  smq_pkg::mode_e       extract_mode;
  smq_pkg::pri_t        target_priority;

  modport source (output valid, cmd, new_priority, new_payload, extract_mode,
                  target_priority, input ready);
  modport sink   (input valid, cmd, new_priority, new_payload, extract_mode,
                  target_priority, output ready);
endinterface

interface smq_out_if;
  logic                 valid;
  logic                 ready;
  smq_pkg::status_e     status;
  smq_pkg::pri_t        out_priority;
  smq_pkg::id_t         out_id;
  smq_pkg::pay_t        out_payload;

  modport source (output valid, status, out_priority, out_id, out_payload,
                  input ready);
  modport sink   (input valid, status, out_priority, out_id, out_payload,
                  output ready);
endinterface

FILE: src/smq_datapath.sv
// Datapath of the message queue: entry registers, compare row and result register.
module smq_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  smq_pkg::ctrl_t     ctrl_i,
  input  smq_pkg::cmd_e      cmd_i,
  input  smq_pkg::pri_t      new_priority_i,
  input  smq_pkg::pay_t      new_payload_i,
  input  smq_pkg::mode_e     extract_mode_i,
  input  smq_pkg::pri_t      target_priority_i,
  output smq_pkg::status_e   status_o,
  output smq_pkg::pri_t      out_priority_o,
  output smq_pkg::id_t       out_id_o,
  output smq_pkg::pay_t      out_payload_o
);

  smq_pkg::pri_t pri_q [smq_pkg::DEPTH];
  smq_pkg::id_t  id_q  [smq_pkg::DEPTH];
  smq_pkg::pay_t pay_q [smq_pkg::DEPTH];

  smq_pkg::cnt_t count_q, count_d;
  smq_pkg::id_t  seq_q, seq_d;

  smq_pkg::cmd_e cmd_q;
  smq_pkg::pri_t npri_q;
  smq_pkg::pay_t npay_q;
  logic [smq_pkg::DEPTH-1:0] hit_q, hit_d;

  smq_pkg::status_e status_q, status_d;
  smq_pkg::pri_t    opri_q, opri_d;
  smq_pkg::id_t     oid_q, oid_d;
  smq_pkg::pay_t    opay_q, opay_d;

  smq_pkg::idx_t pos;
  logic          found;
  logic          full;
  logic          empty;
  logic          do_push;
  logic          do_pop;

  // Compare every live entry against the request while it is accepted.
  always_comb begin
    for (int i = 0; i < smq_pkg::DEPTH; i++) begin
      logic live;
      live = smq_pkg::cnt_t'(i) < count_q;
      case (extract_mode_i)
        smq_pkg::MODE_OLDEST:   hit_d[i] = live && (i == 0);
        smq_pkg::MODE_EXACT:    hit_d[i] = live && (pri_q[i] == target_priority_i);
        smq_pkg::MODE_AT_LEAST: hit_d[i] = live && (pri_q[i] >= target_priority_i);
        default:                hit_d[i] = 1'b0;
      endcase
    end
  end

  // The lowest hit is the oldest matching entry.
  always_comb begin
    found = |hit_q;
    pos   = '0;
    for (int i = smq_pkg::DEPTH - 1; i >= 0; i--) begin
      if (hit_q[i]) pos = smq_pkg::idx_t'(i);
    end
  end

  assign full    = (count_q == smq_pkg::cnt_t'(smq_pkg::DEPTH));
  assign empty   = (count_q == '0);
  assign do_push = ctrl_i.commit && (cmd_q == smq_pkg::CMD_PUSH) && !full;
  assign do_pop  = ctrl_i.commit && (cmd_q == smq_pkg::CMD_EXTRACT) && !empty && found;

  always_comb begin
    count_d  = count_q;
    seq_d    = seq_q;
    status_d = status_q;
    opri_d   = opri_q;
    oid_d    = oid_q;
    opay_d   = opay_q;
    if (ctrl_i.commit) begin
      opri_d = '0;
      oid_d  = '0;
      opay_d = '0;
      if (cmd_q == smq_pkg::CMD_PUSH) begin
        if (full) begin
          status_d = smq_pkg::ST_FULL;
        end else begin
          status_d = smq_pkg::ST_PUSHED;
          count_d  = count_q + smq_pkg::cnt_t'(1);
          seq_d    = seq_q + smq_pkg::id_t'(1);
        end
      end else if (empty) begin
        status_d = smq_pkg::ST_EMPTY;
      end else if (!found) begin
        status_d = smq_pkg::ST_NOMATCH;
      end else begin
        status_d = smq_pkg::ST_EXTRACTED;
        opri_d   = pri_q[pos];
        oid_d    = id_q[pos];
        opay_d   = pay_q[pos];
        count_d  = count_q - smq_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      seq_q   <= smq_pkg::id_t'(1);
    end else begin
      count_q <= count_d;
      seq_q   <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q  <= cmd_i;
      npri_q <= new_priority_i;
      npay_q <= new_payload_i;
      hit_q  <= hit_d;
    end
    status_q <= status_d;
    opri_q   <= opri_d;
    oid_q    <= oid_d;
    opay_q   <= opay_d;
    if (do_push) begin
      pri_q[count_q[smq_pkg::IDX_W-1:0]] <= npri_q;
      id_q[count_q[smq_pkg::IDX_W-1:0]]  <= seq_q;
      pay_q[count_q[smq_pkg::IDX_W-1:0]] <= npay_q;
    end
    if (do_pop) begin
      // Entries above the removed one move down by one place.
      for (int i = 0; i < smq_pkg::DEPTH - 1; i++) begin
        if (smq_pkg::idx_t'(i) >= pos) begin
          pri_q[i] <= pri_q[i+1];
          id_q[i]  <= id_q[i+1];
          pay_q[i] <= pay_q[i+1];
        end
      end
    end
  end

  assign status_o       = status_q;
  assign out_priority_o = opri_q;
  assign out_id_o       = oid_q;
  assign out_payload_o  = opay_q;

endmodule

FILE: src/smq_controller.sv
// Controller of the message queue: sequences capture and commit of each request.
module smq_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_ready_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output smq_pkg::ctrl_t ctrl_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   capture;
  logic   commit;

  assign capture = in_valid_i && (state_q == S_IDLE);
  // A result may only be loaded once the previous one has been taken.
  assign commit  = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (capture) state_d = S_EXEC;
      S_EXEC:  if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    out_valid_d = commit || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign ctrl_o.capture = capture;
  assign ctrl_o.commit  = commit;

endmodule

FILE: src/searchable_message_queue_unit.sv
// Top level of the searchable message queue: controller plus datapath.
//
// The block keeps up to sixteen messages in arrival order, each with an
// 8-bit priority, a 16-bit sequence id and a 64-bit payload. A push transfer
// appends a message and stamps it with the next id, which starts at 1 and
// wraps; a push into a full queue is rejected. An extract transfer removes
// the oldest message, the oldest one whose priority equals the target, or the
// oldest one whose priority is at least the target, and the messages behind
// it close the gap. Every request gives exactly one result transfer carrying
// a status (pushed, full, extracted, empty or no match) and, for an
// extraction, the removed message; the other fields are zero. In the cycle a
// request is accepted, all sixteen stored priorities are compared against
// the target in parallel and the hit vector is registered; then, once the
// previous result has been taken, the first hit is selected, the entry
// registers are written or shifted down by one place, and the output
// register is loaded. A new request is accepted in the cycle after that, so
// the block takes no new request before it is through with the last one. A
// result that is held back delays the commit, not the acceptance of the
// following request. There is no clearing pass after reset: only the fill
// count, the id counter and the controller state are reset.
module searchable_message_queue_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  smq_in_if.sink    in_ch,
  smq_out_if.source out_ch
);

  smq_pkg::ctrl_t ctrl;

  // Sequences each request through its capture and commit cycles.
  smq_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .out_ready_i (out_ch.ready),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .ctrl_o      (ctrl)
  );

  // Holds the queue entries and the result register.
  smq_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .cmd_i             (in_ch.cmd),
    .new_priority_i    (in_ch.new_priority),
    .new_payload_i     (in_ch.new_payload),
    .extract_mode_i    (in_ch.extract_mode),
    .target_priority_i (in_ch.target_priority),
    .status_o          (out_ch.status),
    .out_priority_o    (out_ch.out_priority),
    .out_id_o          (out_ch.out_id),
    .out_payload_o     (out_ch.out_payload)
  );

endmodule

FILE: src/smq_checker.sv
// Port-level assertions of the searchable message queue and their bind.
`include "searchable_message_queue_unit_assert.svh"

module smq_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [2:0]                out_status_i,
  input logic [smq_pkg::PRI_BITS-1:0]     out_priority_i,
  input logic [smq_pkg::ID_BITS-1:0]      out_id_i,
  input logic [smq_pkg::PAYLOAD_BITS-1:0] out_payload_i
);

  // A stalled result keeps its status.
  `SMQ_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_status_i), "result changed while stalled")

  // Only one request is in flight: an accepted request blocks the next cycle.
  `SMQ_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_i, !in_ready_i, "request accepted while busy")

  // Status codes stay within the defined set.
  `SMQ_ASSERT(a_status_code, out_valid_i |-> (out_status_i <= smq_pkg::ST_NOMATCH), "undefined status code")

  // Only an extraction carries a message.
  `SMQ_ASSERT(a_zero_fields, (out_valid_i && (out_status_i != smq_pkg::ST_EXTRACTED)) |-> ((out_priority_i == '0) && (out_id_i == '0) && (out_payload_i == '0)), "fields not zero")

endmodule

bind searchable_message_queue_unit smq_checker u_smq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_ch.valid),
  .in_ready_i     (in_ch.ready),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .out_status_i   (out_ch.status),
  .out_priority_i (out_ch.out_priority),
  .out_id_i       (out_ch.out_id),
  .out_payload_i  (out_ch.out_payload)
);

FILE: tb/tb_top.sv
// Self-checking testbench for the searchable message queue: directed table, random traffic.
module tb_top;

  // A correct run moves some 680 requests, each of which may wait out random gaps
  // on both sides, plus one long hold on the result side; the limit is set well
  // above what such a run needs.
  localparam int CYCLE_LIMIT  = 100_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 120;
  localparam int RANDOM_ITEMS = 650;

  typedef struct {
    smq_pkg::cmd_e  cmd;
    smq_pkg::pri_t  pri;
    smq_pkg::pay_t  payload;
    smq_pkg::mode_e mode;
    smq_pkg::pri_t  target;
  } request_t;

  typedef struct {
    smq_pkg::status_e status;
    smq_pkg::pri_t    pri;
    smq_pkg::id_t     id;
    smq_pkg::pay_t    payload;
  } outcome_t;

  typedef struct {
    smq_pkg::pri_t pri;
    smq_pkg::id_t  id;
    smq_pkg::pay_t payload;
  } message_t;

  // One row of the directed table. A row with reps above one steps the priority
  // by 17 and the payload by one on each repeat.
  typedef struct {
    request_t req;
    int       reps;
    bit       typed;
    outcome_t want;
  } vector_t;

  logic clk_i;
  logic rst_ni;

  smq_in_if  in_ch ();
  smq_out_if out_ch ();

  searchable_message_queue_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the queue contents and of the id counter.
  message_t     shadow_msgs[$];
  smq_pkg::id_t shadow_next_id;
  outcome_t     pending_outcomes[$];
  vector_t      vector_table[$];
  int           mismatches;
  int           src_idle_pct;
  int           sink_idle_pct;
  bit           hold_pending;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Applies one request to the shadow queue and returns the result it must give.
  function automatic outcome_t predict_outcome(input request_t r);
    outcome_t o;
    message_t m;
    int       hit;
    o = '{smq_pkg::ST_PUSHED, '0, '0, '0};
    hit = -1;
    if (r.cmd == smq_pkg::CMD_PUSH) begin
      if (shadow_msgs.size() >= smq_pkg::DEPTH) begin
        o.status = smq_pkg::ST_FULL;
      end else begin
        m = '{r.pri, shadow_next_id, r.payload};
        shadow_msgs.push_back(m);
        shadow_next_id = shadow_next_id + 1'b1;
      end
      return o;
    end
    if (shadow_msgs.size() == 0) begin
      o.status = smq_pkg::ST_EMPTY;
      return o;
    end
    // The oldest entry that qualifies wins; mode none never qualifies.
    for (int i = 0; i < shadow_msgs.size() && hit < 0; i++) begin
      case (r.mode)
        smq_pkg::MODE_OLDEST:   hit = i;
        smq_pkg::MODE_EXACT:    if (shadow_msgs[i].pri == r.target) hit = i;
        smq_pkg::MODE_AT_LEAST: if (shadow_msgs[i].pri >= r.target) hit = i;
        default: ;
      endcase
    end
    if (hit < 0) begin
      o.status = smq_pkg::ST_NOMATCH;
    end else begin
      o.status  = smq_pkg::ST_EXTRACTED;
      o.pri     = shadow_msgs[hit].pri;
      o.id      = shadow_msgs[hit].id;
      o.payload = shadow_msgs[hit].payload;
      shadow_msgs.delete(hit);
    end
    return o;
  endfunction

  function automatic void row_predicted(input smq_pkg::cmd_e c, input smq_pkg::pri_t p,
                                        input smq_pkg::pay_t pay, input smq_pkg::mode_e md,
                                        input smq_pkg::pri_t t, input int reps);
    vector_t v;
    v.req   = '{c, p, pay, md, t};
    v.reps  = reps;
    v.typed = 1'b0;
    v.want  = '{smq_pkg::ST_PUSHED, '0, '0, '0};
    vector_table.push_back(v);
  endfunction

  function automatic void row_typed(input smq_pkg::cmd_e c, input smq_pkg::pri_t p,
                                    input smq_pkg::pay_t pay, input smq_pkg::mode_e md,
                                    input smq_pkg::pri_t t, input smq_pkg::status_e st,
                                    input smq_pkg::pri_t opri, input smq_pkg::id_t oid,
                                    input smq_pkg::pay_t opay);
    vector_t v;
    v.req   = '{c, p, pay, md, t};
    v.reps  = 1;
    v.typed = 1'b1;
    v.want  = '{st, opri, oid, opay};
    vector_table.push_back(v);
  endfunction

  // Random request. Priorities cluster at both ends so that equal priorities
  // are common, and most targets are taken from entries that are stored.
  function automatic request_t random_request(input int push_pct);
    request_t r;
    int       pick;
    r.cmd = ($urandom_range(99) < push_pct) ? smq_pkg::CMD_PUSH : smq_pkg::CMD_EXTRACT;
    pick = $urandom_range(9);
    if (pick < 4)      r.pri = smq_pkg::pri_t'($urandom);
    else if (pick < 7) r.pri = smq_pkg::pri_t'($urandom_range(3));
    else               r.pri = smq_pkg::pri_t'(8'hFF - $urandom_range(3));
    r.payload = {$urandom, $urandom};
    pick = $urandom_range(99);
    r.mode = (pick < 25) ? smq_pkg::MODE_OLDEST :
             (pick < 55) ? smq_pkg::MODE_EXACT :
             (pick < 85) ? smq_pkg::MODE_AT_LEAST : smq_pkg::MODE_NONE;
    if (shadow_msgs.size() != 0 && $urandom_range(99) < 70)
      r.target = shadow_msgs[$urandom_range(shadow_msgs.size() - 1)].pri;
    else
      r.target = smq_pkg::pri_t'($urandom);
    return r;
  endfunction

  // Offers one request after a random gap and waits for its transfer. Called at a
  // falling edge and returns at a falling edge. On acceptance the expectation is
  // queued: the typed one when the table gives it, otherwise the predicted one.
  task automatic send_request(input request_t r, input bit typed, input outcome_t want);
    outcome_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.cmd             <= r.cmd;
    in_ch.new_priority    <= r.pri;
    in_ch.new_payload     <= r.payload;
    in_ch.extract_mode    <= r.mode;
    in_ch.target_priority <= r.target;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predicted = predict_outcome(r);
    pending_outcomes.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  function automatic void check_field(input string label, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
      mismatches++;
    end
  endfunction

  // Result side: random stalls, plus one long hold when the stimulus asks for it.
  initial begin : result_side
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_left    = HOLD_CYCLES;
        hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    outcome_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, out_ch.status);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("status", want.status, out_ch.status);
        check_field("out_priority", want.pri, out_ch.out_priority);
        check_field("out_id", want.id, out_ch.out_id);
        check_field("out_payload", want.payload, out_ch.out_payload);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    request_t r;
    outcome_t no_want;
    no_want               = '{smq_pkg::ST_PUSHED, '0, '0, '0};
    mismatches            = 0;
    hold_pending          = 1'b0;
    shadow_next_id        = smq_pkg::id_t'(1);
    rst_ni                = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.cmd             = smq_pkg::CMD_PUSH;
    in_ch.new_priority    = '0;
    in_ch.new_payload     = '0;
    in_ch.extract_mode    = smq_pkg::MODE_OLDEST;
    in_ch.target_priority = '0;
    src_idle_pct          = 17;
    sink_idle_pct         = 55;

    // Empty queue, then three pushes at the priority extremes and the midpoint, the
    // special extracts on them, then a fill to full with a rejected push and searches.
    row_typed(smq_pkg::CMD_EXTRACT, 8'h00, '0, smq_pkg::MODE_OLDEST, 8'h00,
              smq_pkg::ST_EMPTY, '0, '0, '0);
    row_typed(smq_pkg::CMD_EXTRACT, 8'h00, '0, smq_pkg::MODE_NONE, 8'hFF,
              smq_pkg::ST_EMPTY, '0, '0, '0);
    row_typed(smq_pkg::CMD_PUSH, 8'h00, '0, smq_pkg::MODE_OLDEST, 8'h00,
              smq_pkg::ST_PUSHED, '0, '0, '0);
    row_typed(smq_pkg::CMD_PUSH, 8'hFF, '1, smq_pkg::MODE_OLDEST, 8'h00,
              smq_pkg::ST_PUSHED, '0, '0, '0);
    row_typed(smq_pkg::CMD_PUSH, 8'h80, 64'hA5A5_5A5A_0F0F_F0F0, smq_pkg::MODE_OLDEST,
              8'h00, smq_pkg::ST_PUSHED, '0, '0, '0);
    row_typed(smq_pkg::CMD_EXTRACT, 8'h00, '0, smq_pkg::MODE_NONE, 8'h80,
              smq_pkg::ST_NOMATCH, '0, '0, '0);
    row_typed(smq_pkg::CMD_EXTRACT, 8'h00, '0, smq_pkg::MODE_EXACT, 8'h7F,
              smq_pkg::ST_NOMATCH, '0, '0, '0);
    row_typed(smq_pkg::CMD_EXTRACT, 8'h00, '0, smq_pkg::MODE_AT_LEAST, 8'hFF,
              smq_pkg::ST_EXTRACTED, 8'hFF, smq_pkg::id_t'(2), '1);
    row_typed(smq_pkg::CMD_EXTRACT, 8'h00, '0, smq_pkg::MODE_EXACT, 8'h00,
              smq_pkg::ST_EXTRACTED, 8'h00, smq_pkg::id_t'(1), '0);
    row_typed(smq_pkg::CMD_EXTRACT, 8'h00, '0, smq_pkg::MODE_AT_LEAST, 8'h00,
              smq_pkg::ST_EXTRACTED, 8'h80, smq_pkg::id_t'(3), 64'hA5A5_5A5A_0F0F_F0F0);
    row_predicted(smq_pkg::CMD_PUSH, 8'h10, 64'h0123_4567_89AB_CDEF, smq_pkg::MODE_OLDEST,
                  8'h00, smq_pkg::DEPTH);
    row_typed(smq_pkg::CMD_PUSH, 8'h33, '1, smq_pkg::MODE_OLDEST, 8'h00,
              smq_pkg::ST_FULL, '0, '0, '0);
    row_typed(smq_pkg::CMD_EXTRACT, 8'h00, '0, smq_pkg::MODE_NONE, 8'h00,
              smq_pkg::ST_NOMATCH, '0, '0, '0);
    row_predicted(smq_pkg::CMD_EXTRACT, 8'h00, '0, smq_pkg::MODE_EXACT, 8'h65, 1);
    row_predicted(smq_pkg::CMD_EXTRACT, 8'h00, '0, smq_pkg::MODE_AT_LEAST, 8'hF0, 1);
    row_predicted(smq_pkg::CMD_EXTRACT, 8'h00, '0, smq_pkg::MODE_OLDEST, 8'h00, 1);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (vector_table[n]) begin
      for (int k = 0; k < vector_table[n].reps; k++) begin
        r         = vector_table[n].req;
        r.pri     = r.pri + smq_pkg::pri_t'(k * 17);
        r.payload = r.payload + smq_pkg::pay_t'(k);
        send_request(r, vector_table[n].typed, vector_table[n].want);
      end
    end

    // Random traffic in three idling phases. The push share flips every 40
    // requests so that the queue swings between full and empty.
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct  = (phase == 0) ? 17 : (phase == 1) ? 55 : 0;
      sink_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 17 : 0;
      if (phase == 2) hold_pending = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / 3; n++)
        send_request(random_request(((n / 40) % 2 == 0) ? 70 : 30), 1'b0, no_want);
    end

    in_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
